>>> hdl/fea_pkg.sv
// ----------------------------------------------------------------------------
// fea_pkg
// Shared types and codes of the free extent allocator.
// ----------------------------------------------------------------------------
package fea_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    CFG_INITIAL_END = 1'b0,
    CFG_PAGE_LIMIT  = 1'b1
  } cfg_index_t;

  localparam int unsigned LEN_MAX = 65535;

endpackage

>>> hdl/fea_if.sv
// ----------------------------------------------------------------------------
// fea_req_if / fea_rsp_if
// Valid/ready channels for requests and responses of the allocator.
// ----------------------------------------------------------------------------
interface fea_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  run_length;
  logic [31:0] start_page;
  modport source (output valid, func, run_length, start_page, input ready);
  modport sink   (input valid, func, run_length, start_page, output ready);
endinterface

interface fea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_id;
  logic [1:0]  status;
  logic        recycled;
  modport source (output valid, page_id, status, recycled, input ready);
  modport sink   (input valid, page_id, status, recycled, output ready);
endinterface

>>> hdl/free_extent_allocator.sv
// ----------------------------------------------------------------------------
// free_extent_allocator
// First-fit allocator of page runs over a grouped table of free extents.
// ----------------------------------------------------------------------------
// The block handles one item at a time. The free table lives in one
// synchronous memory of GROUPS*ENTRIES_PER_GROUP entries that is streamed one
// entry per cycle while a group is scanned. Groups whose largest extent is too
// small (alloc) or whose slots are all used (free) are skipped without a scan,
// and a zero run length goes straight to the response. The table is empty
// after reset through per-entry valid bits, so no clearing pass is needed.
// Configuration writes load the end-of-store counter or the page limit and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module free_extent_allocator
  import fea_pkg::*;
#(
  parameter int unsigned GROUPS            = 4,
  parameter int unsigned ENTRIES_PER_GROUP = 16
) (
  input  logic        clk,
  input  logic        rst,
  fea_req_if.sink     req,
  fea_rsp_if.source   rsp,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned DEPTH = GROUPS * ENTRIES_PER_GROUP;
  localparam int unsigned KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned JW = (ENTRIES_PER_GROUP > 1) ? $clog2(ENTRIES_PER_GROUP) : 1;
  localparam int unsigned UW = $clog2(ENTRIES_PER_GROUP + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GRP  = 5'b00010,
    S_SCAN = 5'b00100,
    S_GROW = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  // Free table memory: {start, length} with one valid bit per entry.
  logic [47:0]      mem [DEPTH];
  logic [47:0]      rd_data;
  logic [DEPTH-1:0] vld;
  logic [KW-1:0]    raddr;
  logic             we;
  logic [47:0]      wdata;

  // Group summaries.
  logic [UW-1:0] grp_used [GROUPS];
  logic [31:0]   grp_free [GROUPS];
  logic [15:0]   grp_big  [GROUPS];

  logic [31:0] end_page, page_limit;

  // Item being worked on.
  logic        func;
  logic [7:0]  len;
  logic [31:0] id;
  logic [GW-1:0] g;
  logic [JW-1:0] j;
  logic [KW-1:0] k;
  logic        found;
  logic        emptied;
  logic [15:0] biggest;
  logic [31:0] pid;

  // Result register.
  logic [31:0] r_page;
  status_t     r_status;
  logic        r_rec;

  // Evaluation of the entry that the memory returns.
  logic [31:0] e_start;
  logic [15:0] e_len, a_new, a_eff, f_new, big_next;
  logic        a_hit, f_empty, f_after, f_before, f_fit, f_hit;
  logic        last_g, last_j;

  assign last_g = (g == GW'(GROUPS - 1));
  assign last_j = (j == JW'(ENTRIES_PER_GROUP - 1));

  always_comb begin
    e_start  = rd_data[47:16];
    e_len    = vld[k] ? rd_data[15:0] : 16'd0;
    a_hit    = !found && (e_len != 16'd0) && (e_len >= {8'd0, len});
    a_new    = e_len - {8'd0, len};
    a_eff    = a_hit ? a_new : e_len;
    big_next = (a_eff > biggest) ? a_eff : biggest;
    f_empty  = (e_len == 16'd0);
    f_fit    = ({1'b0, e_len} + {9'd0, len}) < 17'(LEN_MAX);
    f_after  = ({1'b0, e_start} + {17'd0, e_len}) == {1'b0, id};
    f_before = ({1'b0, id} + {25'd0, len}) == {1'b0, e_start};
    f_hit    = f_empty || (f_fit && (f_after || f_before));
    f_new    = f_empty ? {8'd0, len} : e_len + {8'd0, len};
    we       = 1'b0;
    wdata    = rd_data;
    raddr    = (state == S_GRP) ? k : k + KW'(1);
    if (state == S_SCAN) begin
      if (func == FN_ALLOC) begin
        we    = a_hit;
        wdata = {(a_new == 16'd0) ? 32'd0 : e_start + {24'd0, len}, a_new};
      end else begin
        we    = f_hit;
        wdata = {(f_empty || f_before) ? id : e_start, f_new};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[k] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      vld        <= '0;
      end_page   <= 32'd1;
      page_limit <= 32'hFFFF_FFFF;
      for (int i = 0; i < GROUPS; i++) begin
        grp_used[i] <= '0;
        grp_free[i] <= '0;
        grp_big[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_INITIAL_END) begin
          end_page <= cfg_data;
        end else begin
          page_limit <= cfg_data;
        end
      end
      if (we) begin
        vld[k] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func    <= req.func;
            len     <= req.run_length;
            id      <= req.start_page;
            g       <= '0;
            k       <= '0;
            r_page  <= '0;
            r_status <= ST_OK;
            r_rec   <= 1'b0;
            state   <= (req.run_length == 8'd0) ? S_OUT : S_GRP;
          end
        end
        S_GRP: begin
          j       <= '0;
          found   <= 1'b0;
          emptied <= 1'b0;
          biggest <= '0;
          if ((func == FN_ALLOC) ? (grp_big[g] < {8'd0, len})
                                 : (grp_used[g] == UW'(ENTRIES_PER_GROUP))) begin
            if (last_g) begin
              state <= (func == FN_ALLOC) ? S_GROW : S_OUT;
              r_status <= (func == FN_ALLOC) ? ST_OK : ST_FULL;
            end else begin
              g <= g + GW'(1);
              k <= k + KW'(ENTRIES_PER_GROUP);
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          j <= j + JW'(1);
          k <= k + KW'(1);
          if (func == FN_ALLOC) begin
            biggest <= big_next;
            if (a_hit) begin
              found   <= 1'b1;
              pid     <= e_start;
              emptied <= (a_new == 16'd0);
            end
            if (last_j) begin
              if (found || a_hit) begin
                grp_big[g]  <= big_next;
                grp_free[g] <= grp_free[g] - {24'd0, len};
                if (((a_hit && a_new == 16'd0) || emptied) && grp_used[g] != '0) begin
                  grp_used[g] <= grp_used[g] - UW'(1);
                end
                r_page <= a_hit ? e_start : pid;
                r_rec  <= 1'b1;
                state  <= S_OUT;
              end else if (last_g) begin
                state <= S_GROW;
              end else begin
                g     <= g + GW'(1);
                state <= S_GRP;
              end
            end
          end else begin
            if (f_hit) begin
              if (f_empty) begin
                grp_used[g] <= grp_used[g] + UW'(1);
              end
              grp_free[g] <= grp_free[g] + {24'd0, len};
              if (grp_big[g] < f_new) begin
                grp_big[g] <= f_new;
              end
              state <= S_OUT;
            end else if (last_j) begin
              if (last_g) begin
                r_status <= ST_FULL;
                state    <= S_OUT;
              end else begin
                g     <= g + GW'(1);
                state <= S_GRP;
              end
            end
          end
        end
        S_GROW: begin
          // Last new page must not pass the limit; new end must fit 32 bits.
          if (({1'b0, end_page} + {25'd0, len} - 33'd1) > {1'b0, page_limit} ||
              ({1'b0, end_page} + {25'd0, len}) > 33'h0_FFFF_FFFF) begin
            r_status <= ST_NO_SPACE;
          end else begin
            r_page   <= end_page;
            end_page <= end_page + {24'd0, len};
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = (state == S_OUT);
  assign rsp.page_id  = r_page;
  assign rsp.status   = r_status;
  assign rsp.recycled = r_rec;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("request and response open together");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("item accepted while busy");
  a_rec_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.recycled) |-> (rsp.status == ST_OK)) else $error("recycled with error");
  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && func == FN_FREE) |-> (rsp.page_id == 32'd0 && !rsp.recycled))
    else $error("free returned a page");

endmodule

>>> tb/free_extent_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_extent_allocator_tb
// Self-checking testbench of the first-fit free extent allocator.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a driver that works at the falling edge. A
// monitor works at the rising edge and checks every response against a
// page-run model kept in this file. The stimulus starts with directed cases:
// zero-length runs, growth to the page limit and to the 32-bit end, recycling
// and merging on both sides, and a full free table that rejects further frees.
// Random rounds under several register settings follow. Both channels idle at
// random, and once the response side holds off long enough to stall requests.
// ----------------------------------------------------------------------------
module free_extent_allocator_tb;
  import fea_pkg::*;

  localparam int unsigned NGRP  = 4;
  localparam int unsigned NSLOT = 16;
  localparam int unsigned NTAB  = NGRP * NSLOT;
  localparam int unsigned SETTLE_CYCLES = 100;

  typedef struct packed {
    func_t       fn;
    logic [7:0]  len;
    logic [31:0] sp;
  } page_req_t;

  typedef struct packed {
    logic [31:0] pid;
    status_t     st;
    logic        rec;
  } page_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  fea_req_if req ();
  fea_rsp_if rsp ();

  free_extent_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model of the free table, the group summaries and the end-of-store counter.
  logic [31:0] ext_start [NTAB];
  logic [15:0] ext_len   [NTAB];
  int unsigned grp_used  [NGRP];
  logic [31:0] grp_pages [NGRP];
  logic [15:0] grp_big   [NGRP];
  logic [31:0] store_end;
  logic [31:0] store_limit;

  page_req_t pending_reqs [$];
  page_rsp_t expected_rsps [$];

  int unsigned req_gap = 0;
  int unsigned rsp_gap = 0;
  bit          idle_on = 1'b1;
  bit          hold_rsp = 1'b0;
  bit          req_fire = 1'b0;
  bit          rsp_fire = 1'b0;

  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_recycled = 0;
  int unsigned n_grown = 0;
  int unsigned n_no_space = 0;
  int unsigned n_full = 0;
  int unsigned n_merged = 0;

  // Clock and the one reset at the start of the run.
  initial begin
    repeat (6) begin
      #1 clk = 1'b1;
      #1 clk = 1'b0;
    end
    rst = 1'b0;
    forever begin
      #1 clk = ~clk;
    end
  end

  // Model reset, kept in step with the block's reset.
  initial begin
    for (int k = 0; k < NTAB; k++) begin
      ext_start[k] = '0;
      ext_len[k] = '0;
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_used[g] = 0;
      grp_pages[g] = '0;
      grp_big[g] = '0;
    end
    store_end = 32'd1;
    store_limit = 32'hFFFF_FFFF;
  end

  // First-fit allocation: scan groups whose largest extent is big enough and
  // trim the first fitting extent; otherwise grow the store at its end.
  function automatic page_rsp_t take_run(logic [7:0] len);
    page_rsp_t   r;
    logic [15:0] l;
    logic [15:0] biggest;
    logic [63:0] last_pg;
    logic [63:0] next_end;
    bit          found;
    int unsigned k;
    r = '{pid: '0, st: ST_OK, rec: 1'b0};
    for (int g = 0; g < NGRP; g++) begin
      if (grp_big[g] < len) continue;
      found = 1'b0;
      biggest = '0;
      for (int j = 0; j < NSLOT; j++) begin
        k = g * NSLOT + j;
        l = ext_len[k];
        if (!found && l != 0 && l >= len) begin
          r.pid = ext_start[k];
          l = l - len;
          ext_len[k] = l;
          grp_pages[g] = grp_pages[g] - len;
          if (l == 0) begin
            ext_start[k] = '0;
            if (grp_used[g] != 0) grp_used[g]--;
          end else begin
            ext_start[k] = ext_start[k] + len;
          end
          found = 1'b1;
        end
        if (l > biggest) biggest = l;
      end
      if (found) begin
        grp_big[g] = biggest;
        r.rec = 1'b1;
        return r;
      end
    end
    last_pg = {32'd0, store_end} + len - 1;
    next_end = {32'd0, store_end} + len;
    if (last_pg > {32'd0, store_limit} || next_end > 64'hFFFF_FFFF) begin
      r.st = ST_NO_SPACE;
      return r;
    end
    r.pid = store_end;
    store_end = next_end[31:0];
    return r;
  endfunction

  // Release: the first empty slot or the first touching extent wins, groups
  // with every slot used are skipped, and a merge must stay under the cap.
  function automatic page_rsp_t give_run(logic [7:0] len, logic [31:0] sp);
    page_rsp_t   r;
    logic [15:0] l;
    int unsigned k;
    r = '{pid: '0, st: ST_OK, rec: 1'b0};
    for (int g = 0; g < NGRP; g++) begin
      if (grp_used[g] == NSLOT) continue;
      for (int j = 0; j < NSLOT; j++) begin
        k = g * NSLOT + j;
        l = ext_len[k];
        if (l == 0) begin
          ext_start[k] = sp;
          ext_len[k] = {8'd0, len};
          grp_used[g]++;
          grp_pages[g] = grp_pages[g] + len;
          if (grp_big[g] < len) grp_big[g] = {8'd0, len};
          return r;
        end
        if ({16'd0, l} + len >= LEN_MAX) continue;
        if ({32'd0, ext_start[k]} + l == {32'd0, sp}) begin
          // The run follows the extent; its start stays.
        end else if ({32'd0, sp} + len == {32'd0, ext_start[k]}) begin
          ext_start[k] = sp;
        end else begin
          continue;
        end
        l = l + len;
        ext_len[k] = l;
        grp_pages[g] = grp_pages[g] + len;
        if (grp_big[g] < l) grp_big[g] = l;
        n_merged++;
        return r;
      end
    end
    r.st = ST_FULL;
    return r;
  endfunction

  // Driver: holds an offered item until it is taken, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.func <= FN_ALLOC;
      req.run_length <= '0;
      req.start_page <= '0;
    end else if (req.valid && !req_fire) begin
      // Item still on offer.
    end else if (req_gap > 0) begin
      req.valid <= 1'b0;
      req_gap <= req_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      page_req_t it;
      it = pending_reqs.pop_front();
      req.func <= it.fn;
      req.run_length <= it.len;
      req.start_page <= it.sp;
      req.valid <= 1'b1;
      req_gap <= idle_on ? $urandom_range(0, 19) : 0;
    end else begin
      req.valid <= 1'b0;
    end
  end

  // Response side: a random stall per item, plus the long hold when asked.
  always @(negedge clk) begin
    if (rst || hold_rsp) begin
      rsp.ready <= 1'b0;
    end else if (rsp_fire) begin
      rsp.ready <= 1'b0;
      rsp_gap <= idle_on ? $urandom_range(0, 19) : 0;
    end else if (rsp_gap > 0) begin
      rsp.ready <= 1'b0;
      rsp_gap <= rsp_gap - 1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Monitor: predicts on every accepted request and checks every response.
  always @(posedge clk) begin
    req_fire <= !rst && req.valid && req.ready;
    rsp_fire <= !rst && rsp.valid && rsp.ready;
    if (!rst && req.valid && req.ready) begin
      page_rsp_t want;
      n_accepted++;
      if (req.run_length == 0) want = '{pid: '0, st: ST_OK, rec: 1'b0};
      else if (req.func == FN_ALLOC) want = take_run(req.run_length);
      else want = give_run(req.run_length, req.start_page);
      expected_rsps.push_back(want);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      page_rsp_t want;
      if (expected_rsps.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: response with nothing expected: page_id=%h status=%0d recycled=%0b",
                   rsp.page_id, rsp.status, rsp.recycled);
      end else begin
        want = expected_rsps.pop_front();
        n_checked++;
        if (rsp.page_id !== want.pid || rsp.status !== want.st ||
            rsp.recycled !== want.rec) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: response %0d: page_id %h/%h status %0d/%0d recycled %0b/%0b %s",
                     n_checked, want.pid, rsp.page_id, want.st, rsp.status,
                     want.rec, rsp.recycled, "(expected/actual)");
        end
        if (want.st == ST_NO_SPACE) n_no_space++;
        else if (want.st == ST_FULL) n_full++;
        else if (want.rec) n_recycled++;
        else if (want.pid != 0) n_grown++;
      end
    end
  end

  task automatic queue_item(func_t fn, logic [7:0] len, logic [31:0] sp);
    pending_reqs.push_back('{fn: fn, len: len, sp: sp});
  endtask

  // Waits until every queued item was sent and answered, then lets the block
  // settle.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write while idle; the model takes the value at the same edge.
  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_INITIAL_END) store_end = val;
    else store_limit = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random round: mostly small runs on a coarse grid so that frees touch
  // earlier extents and allocations recycle them; some fully random fields.
  task automatic random_round(int unsigned count, logic [31:0] base);
    logic [7:0]  len;
    logic [31:0] sp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) len = 8'($urandom_range(1, 8));
      else len = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 55) begin
        queue_item(FN_ALLOC, len, $urandom);
      end else if ($urandom_range(0, 99) < 85) begin
        sp = base + 8 * $urandom_range(0, 300);
        queue_item(FN_FREE, 8'd8, sp);
      end else begin
        queue_item(FN_FREE, len, $urandom);
      end
    end
  endtask

  // Long hold of the response side once enough traffic has gone through, so
  // that the block backs up and stops taking requests.
  initial begin
    wait (n_accepted >= 500);
    @(posedge clk);
    hold_rsp = 1'b1;
    repeat (600) @(posedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    wait (!rst);
    repeat (2) @(posedge clk);

    // Zero-length runs, growth from the reset end, recycling and merges on
    // both sides, and the extreme start pages.
    queue_item(FN_ALLOC, 8'd0, 32'hFFFF_FFFF);
    queue_item(FN_FREE, 8'd0, 32'h1234_5678);
    queue_item(FN_ALLOC, 8'd1, 32'd0);
    queue_item(FN_ALLOC, 8'd255, 32'd0);
    queue_item(FN_FREE, 8'd10, 32'd1000);
    queue_item(FN_FREE, 8'd5, 32'd1010);
    queue_item(FN_FREE, 8'd5, 32'd995);
    queue_item(FN_ALLOC, 8'd3, 32'd0);
    queue_item(FN_ALLOC, 8'd17, 32'd0);
    queue_item(FN_ALLOC, 8'd200, 32'd0);
    queue_item(FN_FREE, 8'd255, 32'hFFFF_FFFF);
    queue_item(FN_FREE, 8'd1, 32'd0);
    queue_item(FN_ALLOC, 8'd1, 32'd0);
    queue_item(FN_ALLOC, 8'd128, 32'd0);
    wait_idle();

    // The page limit stops growth; the last page may equal the limit.
    write_reg(CFG_INITIAL_END, 32'd1);
    write_reg(CFG_PAGE_LIMIT, 32'd300);
    queue_item(FN_ALLOC, 8'd255, 32'd0);
    queue_item(FN_ALLOC, 8'd45, 32'd0);
    queue_item(FN_ALLOC, 8'd255, 32'd0);
    queue_item(FN_ALLOC, 8'd1, 32'd0);
    wait_idle();

    // Growth up to the top of the 32-bit page space, then past it.
    write_reg(CFG_INITIAL_END, 32'hFFFF_FF00);
    write_reg(CFG_PAGE_LIMIT, 32'hFFFF_FFFF);
    queue_item(FN_ALLOC, 8'd255, 32'd0);
    queue_item(FN_ALLOC, 8'd255, 32'd0);
    queue_item(FN_ALLOC, 8'd1, 32'd0);
    wait_idle();

    // Isolated single pages fill every slot; the table then reports full.
    for (int i = 0; i < NTAB + 4; i++)
      queue_item(FN_FREE, 8'd1, 32'd1_000_000 + 1000 * i);
    wait_idle();

    // One allocation trims the first slot but leaves it in use; contiguous
    // frees then find the table full, and random allocations follow.
    queue_item(FN_ALLOC, 8'd1, 32'd0);
    for (int i = 0; i < 260; i++)
      queue_item(FN_FREE, 8'd255, 32'h8000_0000 + 255 * i);
    for (int i = 0; i < 40; i++)
      queue_item(FN_ALLOC, 8'($urandom_range(1, 255)), 32'd0);
    wait_idle();

    // Random rounds under several settings, the extremes among them.
    write_reg(CFG_INITIAL_END, 32'd1);
    write_reg(CFG_PAGE_LIMIT, 32'hFFFF_FFFF);
    random_round(350, 32'h0001_0000);
    wait_idle();
    write_reg(CFG_INITIAL_END, 32'h0000_1000);
    write_reg(CFG_PAGE_LIMIT, 32'h0000_1800);
    random_round(300, 32'h0002_0000);
    wait_idle();
    idle_on = 1'b0;
    write_reg(CFG_INITIAL_END, 32'hFFFF_F000);
    write_reg(CFG_PAGE_LIMIT, 32'hFFFF_FFFF);
    random_round(150, 32'hFFF0_0000);
    wait_idle();
    idle_on = 1'b1;
    write_reg(CFG_INITIAL_END, $urandom_range(1, 32'h7FFF_FFFF));
    write_reg(CFG_PAGE_LIMIT, $urandom_range(32'h8000_0000, 32'hFFFF_FFFE));
    random_round(250, 32'h0003_0000);
    wait_idle();

    $display("Checked %0d responses: %0d recycled, %0d grown, %0d merged frees,",
             n_checked, n_recycled, n_grown, n_merged);
    $display("%0d out of space, %0d table full; %0d mismatches.",
             n_no_space, n_full, n_errors);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("Timeout with %0d responses outstanding.", expected_rsps.size());
    $display("FAILURE");
    $finish;
  end

endmodule
